### sv/pht_pkg.sv
// Shared types and constants for the PS/2 host byte transceiver.
`default_nettype none

package pht_pkg;

  localparam int unsigned WaitW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitIdxW = 4;

  // Reset values of the timing registers, and the fixed receive start delay.
  localparam logic [WaitW-1:0] ReleaseTicksRst = 16'd300;
  localparam logic [WaitW-1:0] InhibitTicksRst = 16'd300;
  localparam logic [WaitW-1:0] StartSetupTicksRst = 16'd10;
  localparam logic [WaitW-1:0] SettleTicksRst = 16'd50;
  localparam logic [WaitW-1:0] RxStartDelay = 16'd5;

  // Parity bit index (one past the last data bit) and the index after the stop bit.
  localparam logic [BitIdxW-1:0] LastDataBit = 4'd8;
  localparam logic [BitIdxW-1:0] RxFrameEnd = 4'd10;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2,
    MODE_NONE = 2'd3
  } pht_mode_t;

  typedef enum logic [1:0] {
    REG_RELEASE = 2'd0,
    REG_INHIBIT = 2'd1,
    REG_START_SETUP = 2'd2,
    REG_SETTLE = 2'd3
  } pht_reg_t;

  typedef enum logic [15:0] {
    PH_IDLE        = 16'h0001,
    PH_S_REL       = 16'h0002,
    PH_S_INH       = 16'h0004,
    PH_S_RTS       = 16'h0008,
    PH_S_DEVLOW    = 16'h0010,
    PH_S_BITHIGH   = 16'h0020,
    PH_S_BITLOW    = 16'h0040,
    PH_S_SETTLE    = 16'h0080,
    PH_S_ACKLOW    = 16'h0100,
    PH_S_ACKREL    = 16'h0200,
    PH_R_SETTLE    = 16'h0400,
    PH_R_STARTLOW  = 16'h0800,
    PH_R_DELAY     = 16'h1000,
    PH_R_STARTHIGH = 16'h2000,
    PH_R_BITLOW    = 16'h4000,
    PH_R_BITHIGH   = 16'h8000
  } pht_phase_t;

  // Declared from the top bit down so that the last field, clock_drive_low, lands in bit 0.
  typedef struct packed {
    logic             busy_res;
    logic             send_done;
    logic             receive_done;
    logic [ByteW-1:0] received_byte;
    logic             data_drive_low;
    logic             clock_drive_low;
  } pht_res_t;

  localparam int unsigned ResW = $bits(pht_res_t);

endpackage

`default_nettype wire

### sv/ps2_host_byte_transceiver_top.sv
// Top level of the PS/2 host byte transceiver with its output buffering.
//
//  channel  direction  contents
//  in_      slave      tuser: mode; tdata: send_byte, clock_line, data_line
//  out_     master     tdata: line drives, received byte, done flags, busy
//  cfg_     write      timing register index and 16-bit value
//
// One beat in gives one beat out. A beat is taken every cycle while in_tready
// is high, and its result is registered in the output buffer.
// The state update for a beat is combinational logic in the core.
// A two-entry output buffer lets input keep flowing while the output stalls
// and one entry is free; in_tready drops only while both entries hold results.
// Reset is synchronous and active low and returns the link to idle, released.
`default_nettype none

module ps2_host_byte_transceiver_top
  import pht_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // send_byte[7:0], clock_line[8], data_line[9]
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // clock_drive_low[0], data_drive_low[1],
                                       // received_byte[9:2], receive_done[10],
                                       // send_done[11], busy_res[12]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic     in_fire;
  pht_res_t step_res;
  pht_res_t out_r, skid_r;
  logic     out_v_r, skid_v_r;
  logic     out_take;

  assign in_tready = ~skid_v_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_take  = out_v_r & out_tready;

  pht_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .step_en    (in_fire),
    .mode       (in_tuser),
    .send_byte  (in_tdata[7:0]),
    .clock_line (in_tdata[8]),
    .data_line  (in_tdata[9]),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_take) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_v_r || out_take) begin
          out_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (!out_v_r || out_take) begin
        out_r <= step_res;
      end else begin
        skid_r <= step_res;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(16 - ResW){1'b0}}, out_r};

endmodule

`default_nettype wire

### sv/pht_core.sv
// Protocol state machine and timing registers of the PS/2 host transceiver.
`default_nettype none

module pht_core
  import pht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [WaitW-1:0] cfg_wdata,
  input  wire logic             step_en,
  input  wire logic [1:0]       mode,
  input  wire logic [ByteW-1:0] send_byte,
  input  wire logic             clock_line,
  input  wire logic             data_line,
  output pht_res_t              res
);

  logic [WaitW-1:0] release_ticks_r, inhibit_ticks_r, start_setup_ticks_r, settle_ticks_r;

  pht_phase_t         phase_r, phase_nxt;
  logic [WaitW-1:0]   wait_r, wait_nxt;
  logic [ByteW-1:0]   shift_r, shift_nxt;
  logic [BitIdxW-1:0] bit_idx_r, bit_idx_nxt;
  logic               parity_r, parity_nxt;
  logic               clk_hold_r, clk_hold_nxt;
  logic               dat_hold_r, dat_hold_nxt;
  logic [ByteW-1:0]   rx_byte_r, rx_byte_nxt;
  logic               rx_done, tx_done;
  logic               wait_done;
  logic [BitIdxW-1:0] bit_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_ticks_r     <= ReleaseTicksRst;
      inhibit_ticks_r     <= InhibitTicksRst;
      start_setup_ticks_r <= StartSetupTicksRst;
      settle_ticks_r      <= SettleTicksRst;
    end else if (cfg_we) begin
      unique case (pht_reg_t'(cfg_index))
        REG_RELEASE:     release_ticks_r     <= cfg_wdata;
        REG_INHIBIT:     inhibit_ticks_r     <= cfg_wdata;
        REG_START_SETUP: start_setup_ticks_r <= cfg_wdata;
        REG_SETTLE:      settle_ticks_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign wait_done = (wait_r == '0);
  assign bit_inc   = bit_idx_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    shift_nxt    = shift_r;
    bit_idx_nxt  = bit_idx_r;
    parity_nxt   = parity_r;
    clk_hold_nxt = clk_hold_r;
    dat_hold_nxt = dat_hold_r;
    rx_byte_nxt  = rx_byte_r;
    rx_done      = 1'b0;
    tx_done      = 1'b0;

    if (phase_r == PH_IDLE && pht_mode_t'(mode) == MODE_SEND) begin
      clk_hold_nxt = 1'b0;
      dat_hold_nxt = 1'b0;
      shift_nxt    = send_byte;
      bit_idx_nxt  = '0;
      parity_nxt   = 1'b1;
      wait_nxt     = release_ticks_r;
      phase_nxt    = PH_S_REL;
    end else if (phase_r == PH_IDLE && pht_mode_t'(mode) == MODE_RECV) begin
      clk_hold_nxt = 1'b0;
      dat_hold_nxt = 1'b0;
      shift_nxt    = '0;
      bit_idx_nxt  = '0;
      wait_nxt     = settle_ticks_r;
      phase_nxt    = PH_R_SETTLE;
    end else begin
      // Every counted wait decrements until zero, then acts on the next tick.
      if (!wait_done) begin
        wait_nxt = wait_r - 1'b1;
      end
      unique case (phase_r)
        PH_IDLE: ;
        PH_S_REL: begin
          if (wait_done) begin
            clk_hold_nxt = 1'b1;
            wait_nxt     = inhibit_ticks_r;
            phase_nxt    = PH_S_INH;
          end
        end
        PH_S_INH: begin
          if (wait_done) begin
            dat_hold_nxt = 1'b1;
            wait_nxt     = start_setup_ticks_r;
            phase_nxt    = PH_S_RTS;
          end
        end
        PH_S_RTS: begin
          if (wait_done) begin
            clk_hold_nxt = 1'b0;
            phase_nxt    = PH_S_DEVLOW;
          end
        end
        PH_S_DEVLOW: begin
          if (!clock_line) begin
            bit_idx_nxt  = '0;
            dat_hold_nxt = ~shift_r[0];
            parity_nxt   = parity_r ^ shift_r[0];
            shift_nxt    = shift_r >> 1;
            phase_nxt    = PH_S_BITHIGH;
          end
        end
        PH_S_BITHIGH: begin
          if (clock_line) begin
            phase_nxt = PH_S_BITLOW;
          end
        end
        PH_S_BITLOW: begin
          if (!clock_line) begin
            if (bit_idx_r >= LastDataBit) begin
              dat_hold_nxt = 1'b0;
              wait_nxt     = settle_ticks_r;
              phase_nxt    = PH_S_SETTLE;
            end else begin
              bit_idx_nxt = bit_inc;
              phase_nxt   = PH_S_BITHIGH;
              if (bit_inc < LastDataBit) begin
                dat_hold_nxt = ~shift_r[0];
                parity_nxt   = parity_r ^ shift_r[0];
                shift_nxt    = shift_r >> 1;
              end else begin
                // Parity bit after the eighth data bit.
                dat_hold_nxt = ~parity_r;
              end
            end
          end
        end
        PH_S_SETTLE: begin
          if (wait_done) begin
            phase_nxt = PH_S_ACKLOW;
          end
        end
        PH_S_ACKLOW: begin
          if (!clock_line) begin
            phase_nxt = PH_S_ACKREL;
          end
        end
        PH_S_ACKREL: begin
          if (clock_line && data_line) begin
            clk_hold_nxt = 1'b1;
            tx_done      = 1'b1;
            phase_nxt    = PH_IDLE;
          end
        end
        PH_R_SETTLE: begin
          if (wait_done) begin
            phase_nxt = PH_R_STARTLOW;
          end
        end
        PH_R_STARTLOW: begin
          if (!clock_line) begin
            wait_nxt  = RxStartDelay;
            phase_nxt = PH_R_DELAY;
          end
        end
        PH_R_DELAY: begin
          if (wait_done) begin
            phase_nxt = PH_R_STARTHIGH;
          end
        end
        PH_R_STARTHIGH: begin
          if (clock_line) begin
            bit_idx_nxt = '0;
            phase_nxt   = PH_R_BITLOW;
          end
        end
        PH_R_BITLOW: begin
          if (!clock_line) begin
            if (bit_idx_r < LastDataBit) begin
              shift_nxt[bit_idx_r[2:0]] = shift_r[bit_idx_r[2:0]] | data_line;
            end
            phase_nxt = PH_R_BITHIGH;
          end
        end
        PH_R_BITHIGH: begin
          if (clock_line) begin
            bit_idx_nxt = bit_inc;
            if (bit_inc >= RxFrameEnd) begin
              clk_hold_nxt = 1'b1;
              rx_byte_nxt  = shift_r;
              rx_done      = 1'b1;
              phase_nxt    = PH_IDLE;
            end else begin
              phase_nxt = PH_R_BITLOW;
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      wait_r     <= '0;
      shift_r    <= '0;
      bit_idx_r  <= '0;
      parity_r   <= 1'b1;
      clk_hold_r <= 1'b0;
      dat_hold_r <= 1'b0;
      rx_byte_r  <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      wait_r     <= wait_nxt;
      shift_r    <= shift_nxt;
      bit_idx_r  <= bit_idx_nxt;
      parity_r   <= parity_nxt;
      clk_hold_r <= clk_hold_nxt;
      dat_hold_r <= dat_hold_nxt;
      rx_byte_r  <= rx_byte_nxt;
    end
  end

  always_comb begin
    res.clock_drive_low = clk_hold_nxt;
    res.data_drive_low  = dat_hold_nxt;
    res.received_byte   = rx_byte_nxt;
    res.receive_done    = rx_done;
    res.send_done       = tx_done;
    res.busy_res        = (phase_nxt != PH_IDLE);
  end

endmodule

`default_nettype wire

### sim/pht_link_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every result beat of the PS/2 host transceiver and compares it.
module pht_link_checker
  import pht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          err_count,
  output int          pending,
  output logic        link_busy
);

  logic [WaitW-1:0] t_release, t_inhibit, t_setup, t_settle;

  pht_phase_t         ph;
  logic [WaitW-1:0]   wait_cnt;
  logic [ByteW-1:0]   sh_byte;
  logic [ByteW-1:0]   rx_byte;
  logic [BitIdxW-1:0] bit_idx;
  logic               par;
  logic               clk_hold;
  logic               dat_hold;

  pht_res_t link_q[$];
  int       n_err = 0;
  int       n_seen = 0;

  function automatic bit count_done();
    if (wait_cnt == '0) return 1'b1;
    wait_cnt = wait_cnt - 1'b1;
    return 1'b0;
  endfunction

  // Data bits go out LSB first; after them the odd parity bit.
  function automatic void put_tx_bit();
    if (bit_idx < LastDataBit) begin
      dat_hold = ~sh_byte[0];
      par = par ^ sh_byte[0];
      sh_byte = sh_byte >> 1;
    end else begin
      dat_hold = ~par;
    end
  endfunction

  function automatic pht_res_t link_step(pht_mode_t mode, logic [ByteW-1:0] tx_val,
                                         logic c, logic d);
    pht_res_t r;
    logic     rx_done;
    logic     tx_done;
    rx_done = 1'b0;
    tx_done = 1'b0;
    if (ph == PH_IDLE && mode == MODE_SEND) begin
      clk_hold = 1'b0;
      dat_hold = 1'b0;
      sh_byte = tx_val;
      bit_idx = '0;
      par = 1'b1;
      wait_cnt = t_release;
      ph = PH_S_REL;
    end else if (ph == PH_IDLE && mode == MODE_RECV) begin
      clk_hold = 1'b0;
      dat_hold = 1'b0;
      sh_byte = '0;
      bit_idx = '0;
      wait_cnt = t_settle;
      ph = PH_R_SETTLE;
    end else begin
      case (ph)
        PH_S_REL: if (count_done()) begin
          clk_hold = 1'b1;
          wait_cnt = t_inhibit;
          ph = PH_S_INH;
        end
        PH_S_INH: if (count_done()) begin
          dat_hold = 1'b1;
          wait_cnt = t_setup;
          ph = PH_S_RTS;
        end
        PH_S_RTS: if (count_done()) begin
          clk_hold = 1'b0;
          ph = PH_S_DEVLOW;
        end
        PH_S_DEVLOW: if (!c) begin
          bit_idx = '0;
          put_tx_bit();
          ph = PH_S_BITHIGH;
        end
        PH_S_BITHIGH: if (c) ph = PH_S_BITLOW;
        PH_S_BITLOW: if (!c) begin
          if (bit_idx >= LastDataBit) begin
            dat_hold = 1'b0;
            wait_cnt = t_settle;
            ph = PH_S_SETTLE;
          end else begin
            bit_idx = bit_idx + 1'b1;
            put_tx_bit();
            ph = PH_S_BITHIGH;
          end
        end
        PH_S_SETTLE: if (count_done()) ph = PH_S_ACKLOW;
        PH_S_ACKLOW: if (!c) ph = PH_S_ACKREL;
        PH_S_ACKREL: if (c && d) begin
          clk_hold = 1'b1;
          tx_done = 1'b1;
          ph = PH_IDLE;
        end
        PH_R_SETTLE: if (count_done()) ph = PH_R_STARTLOW;
        PH_R_STARTLOW: if (!c) begin
          wait_cnt = RxStartDelay;
          ph = PH_R_DELAY;
        end
        PH_R_DELAY: if (count_done()) ph = PH_R_STARTHIGH;
        PH_R_STARTHIGH: if (c) begin
          bit_idx = '0;
          ph = PH_R_BITLOW;
        end
        PH_R_BITLOW: if (!c) begin
          // Parity and stop are sampled past the data bits and simply dropped.
          if (bit_idx < LastDataBit) sh_byte[bit_idx[2:0]] = sh_byte[bit_idx[2:0]] | d;
          ph = PH_R_BITHIGH;
        end
        PH_R_BITHIGH: if (c) begin
          bit_idx = bit_idx + 1'b1;
          if (bit_idx >= RxFrameEnd) begin
            clk_hold = 1'b1;
            rx_byte = sh_byte;
            rx_done = 1'b1;
            ph = PH_IDLE;
          end else begin
            ph = PH_R_BITLOW;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    r.clock_drive_low = clk_hold;
    r.data_drive_low = dat_hold;
    r.received_byte = rx_byte;
    r.receive_done = rx_done;
    r.send_done = tx_done;
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  function automatic void note_fail(string msg);
    n_err++;
    if (n_err <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    pht_res_t got;
    pht_res_t want;
    if (!rst_n) begin
      t_release = ReleaseTicksRst;
      t_inhibit = InhibitTicksRst;
      t_setup = StartSetupTicksRst;
      t_settle = SettleTicksRst;
      ph = PH_IDLE;
      wait_cnt = '0;
      sh_byte = '0;
      rx_byte = '0;
      bit_idx = '0;
      par = 1'b1;
      clk_hold = 1'b0;
      dat_hold = 1'b0;
      link_q.delete();
    end else begin
      if (cfg_we) begin
        case (pht_reg_t'(cfg_index))
          REG_RELEASE:     t_release = cfg_wdata;
          REG_INHIBIT:     t_inhibit = cfg_wdata;
          REG_START_SETUP: t_setup = cfg_wdata;
          REG_SETTLE:      t_settle = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        link_q.push_back(link_step(pht_mode_t'(in_tuser), in_tdata[7:0],
                                   in_tdata[8], in_tdata[9]));
      end
      if (out_tvalid && out_tready) begin
        got = pht_res_t'(out_tdata[ResW-1:0]);
        if (link_q.size() == 0) begin
          note_fail($sformatf("result %0d arrived with nothing expected: %h", n_seen,
                              out_tdata));
        end else begin
          want = link_q.pop_front();
          if (got !== want || out_tdata[15:ResW] !== '0) begin
            note_fail($sformatf({"result %0d mismatch: expected clk_low=%b dat_low=%b ",
                                 "rx=%h rx_done=%b tx_done=%b busy=%b pad=0, got ",
                                 "clk_low=%b dat_low=%b rx=%h rx_done=%b tx_done=%b ",
                                 "busy=%b pad=%h"}, n_seen,
                                want.clock_drive_low, want.data_drive_low,
                                want.received_byte, want.receive_done, want.send_done,
                                want.busy_res, got.clock_drive_low, got.data_drive_low,
                                got.received_byte, got.receive_done, got.send_done,
                                got.busy_res, out_tdata[15:ResW]));
          end
        end
        n_seen++;
      end
    end
    pending <= link_q.size();
    link_busy <= (ph != PH_IDLE);
    err_count <= n_err;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the PS/2 host transceiver: stimulus, device clocking and verdict.
module tb;
  import pht_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = MODE_TICK;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_RELEASE;
  logic [15:0] cfg_wdata = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  int   err_count;
  int   pending;
  logic link_busy;

  bit   idle_en = 1'b1;
  int   stall_left = 0;
  logic dev_clk = 1'b1;
  int   dev_hold = 0;

  always #5 clk = ~clk;

  ps2_host_byte_transceiver_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pht_link_checker link_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .err_count  (err_count),
    .pending    (pending),
    .link_busy  (link_busy)
  );

  // Result-side back-pressure: mostly short stalls, a few long ones, some long open runs.
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
    end else if (!idle_en) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_tready <= 1'b1;
        stall_left = $urandom_range(0, 7);
      end else if (r < 90) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else if (r < 97) begin
        out_tready <= 1'b1;
        stall_left = $urandom_range(30, 120);
      end else begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 3));
    if (r < 85) return 16'($urandom_range(4, 15));
    return 16'($urandom_range(16, 60));
  endfunction

  // The emulated device runs its clock on the sample ticks; jitter stretches half periods.
  function automatic logic next_dev_clock(bit jitter);
    int r;
    if (dev_hold > 0) begin
      dev_hold--;
    end else begin
      dev_clk = ~dev_clk;
      r = $urandom_range(0, 99);
      if (!jitter || r < 65) dev_hold = 0;
      else if (r < 95) dev_hold = $urandom_range(1, 2);
      else dev_hold = $urandom_range(3, 8);
    end
    return dev_clk;
  endfunction

  task automatic put_beat(input pht_mode_t m, input logic [7:0] b, input logic c,
                          input logic d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= {6'b0, d, c, b};
    do @(posedge clk); while (!in_tready);
  endtask

  // Clock the device until the link goes idle. Strict mode keeps data high so the
  // acknowledge is seen on the first high clock.
  task automatic finish_link(input bit jitter);
    do begin
      put_beat(MODE_TICK, 8'($urandom), next_dev_clock(jitter),
               jitter ? logic'($urandom_range(0, 1)) : 1'b1);
    end while (link_busy);
  endtask

  task automatic load_timing(input logic [15:0] rel, input logic [15:0] inh,
                             input logic [15:0] setup, input logic [15:0] settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_RELEASE;
    cfg_wdata <= rel;
    @(posedge clk);
    cfg_index <= REG_INHIBIT;
    cfg_wdata <= inh;
    @(posedge clk);
    cfg_index <= REG_START_SETUP;
    cfg_wdata <= setup;
    @(posedge clk);
    cfg_index <= REG_SETTLE;
    cfg_wdata <= settle;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic rand_beat();
    int        r;
    pht_mode_t m;
    r = $urandom_range(0, 99);
    if (!link_busy)
      m = (r < 40) ? MODE_SEND : (r < 80) ? MODE_RECV : (r < 90) ? MODE_TICK : MODE_NONE;
    else
      m = (r < 94) ? MODE_TICK : (r < 96) ? MODE_SEND : (r < 98) ? MODE_RECV : MODE_NONE;
    put_beat(m, 8'($urandom), next_dev_clock(1'b1), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int i;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One receive on the timing the registers come out of reset with.
    put_beat(MODE_RECV, 8'($urandom), 1'b1, 1'b1);
    finish_link(1'b1);

    load_timing('0, '0, '0, '0);
    dev_clk = 1'b1;
    put_beat(MODE_TICK, 8'hFF, 1'b1, 1'b1);
    put_beat(MODE_NONE, 8'h00, 1'b0, 1'b0);
    // The line levels on a start beat must not matter.
    put_beat(MODE_SEND, 8'h00, 1'b0, 1'b0);
    // Requests and the unused mode during a transfer act as plain ticks.
    put_beat(MODE_RECV, 8'hFF, 1'b1, 1'b1);
    put_beat(MODE_SEND, 8'hFF, 1'b0, 1'b1);
    put_beat(MODE_NONE, 8'h5A, 1'b1, 1'b0);
    finish_link(1'b0);
    // Between transfers the clock stays held low.
    put_beat(MODE_TICK, 8'h00, 1'b1, 1'b1);
    put_beat(MODE_RECV, 8'h00, 1'b0, 1'b0);
    finish_link(1'b0);
    put_beat(MODE_SEND, 8'hFF, 1'b1, 1'b1);
    finish_link(1'b0);

    for (int round = 0; round < 3; round++) begin
      load_timing(pick_wait(), pick_wait(), pick_wait(), pick_wait());
      for (int k = 0; k < 265; k++) begin
        if (k % 50 == 0) idle_en = ($urandom_range(0, 4) != 0);
        rand_beat();
      end
      finish_link(1'b1);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 20000 && pending != 0; i++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
